// ===== hdl/lnkdq_pkg.sv =====
// Shared types and default sizes of the linked deque manager
`timescale 1ns / 1ps
`default_nettype none

package lnkdq_pkg;

  // default pool and header counts
  localparam int unsigned NUM_ENTRIES_DEF = 256;
  localparam int unsigned NUM_QUEUES_DEF  = 4;

  // field widths of the stream payloads
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned QIDX_W   = 2;
  localparam int unsigned EIDX_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 3;

  // request kinds, the remaining codes do nothing
  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_REM_HEAD = 3'd2,
    KIND_REM_TAIL = 3'd3,
    KIND_UNLINK   = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_MORE     = 2'd0,
    STS_ONE      = 2'd1,
    STS_WASEMPTY = 2'd2,
    STS_NOWEMPTY = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== hdl/linked_deque_manager.sv =====
// Top level of the linked deque manager: request decode, link memories, sequencer
//
// Keeps NUM_QUEUES doubly linked circular queues over a pool of NUM_ENTRIES
// entries. Entries and queue headers share one node space (header q is node
// NUM_ENTRIES + q) held in two synchronous link memories, next and prev.
// Slave channel: one request per transaction, tuser = kind, tdata = queue index
// and entry index. Master channel: one result per request, tuser = status and
// entry valid, tdata = removed entry (zero when no entry was removed).
// Each request is sequenced around the registered read of the link memories
// and their single write port: a removal reads the header, then the entry,
// then writes two rounds. A new request is taken only once the sequencer is
// back in its idle state.
// After reset a pass over the NUM_QUEUES headers points every header at itself;
// no request is taken during it. Entry membership bits clear at reset.
// A result waits in the output register while the receiver stalls; no new
// request is taken until that register is free or drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module linked_deque_manager #(
  parameter int unsigned NUM_ENTRIES = lnkdq_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned NUM_QUEUES  = lnkdq_pkg::NUM_QUEUES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: queue_index [1:0], entry_index [9:2], zero [15:10]
  input  wire logic [lnkdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind [2:0]
  input  wire logic [lnkdq_pkg::KIND_W-1:0]       s_axis_tuser,
  // result channel
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: removed_entry [7:0]
  output logic [lnkdq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // tuser: status [1:0], entry_valid [2]
  output logic [lnkdq_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
  import lnkdq_pkg::*;

  localparam int unsigned NUM_NODES = NUM_ENTRIES + NUM_QUEUES;
  localparam int unsigned NODE_W    = $clog2(NUM_NODES);
  localparam int unsigned ENTRY_W   = $clog2(NUM_ENTRIES);
  localparam int unsigned QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DET2,
    S_INS2
  } state_e;

  state_e              state_q;
  logic [QW-1:0]       init_cnt_q;
  kind_e               kind_q;
  logic [NODE_W-1:0]   h_q, e_q, f_q, l_q, p_q, n_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic                out_evalid_q;
  logic [EIDX_W-1:0]   out_entry_q;
  logic [NUM_ENTRIES-1:0] in_queue_q;

  // link memories
  logic [NODE_W-1:0]   next_mem [NUM_NODES];
  logic [NODE_W-1:0]   prev_mem [NUM_NODES];
  logic [NODE_W-1:0]   next_rd_q, prev_rd_q;
  logic [NODE_W-1:0]   rd_addr;
  logic                nx_we, pv_we;
  logic [NODE_W-1:0]   nx_wa, nx_wd, pv_wa, pv_wd;
  logic                iq_set, iq_clr;

  // request decode
  kind_e               in_kind;
  logic [QIDX_W-1:0]   in_q;
  logic [EIDX_W-1:0]   in_e;
  logic                e_ok, q_ok, in_linked, go;
  logic [NODE_W-1:0]   in_e_node, in_h, x_sel, hdr_init;
  logic                x_ok, in_acc;
  status_e             rem_status, ins_status;
  logic [NODE_W-1:0]   first_new, last_new, ins_other;
  logic [31:0]         e_q_w;

  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_q      = s_axis_tdata[QIDX_W-1:0];
  assign in_e      = s_axis_tdata[QIDX_W+EIDX_W-1:QIDX_W];
  assign e_ok      = 32'(in_e) < NUM_ENTRIES;
  assign q_ok      = 32'(in_q) < NUM_QUEUES;
  assign in_e_node = NODE_W'(32'(in_e));
  assign in_h      = NODE_W'(NUM_ENTRIES + 32'(in_q));
  assign in_linked = in_queue_q[ENTRY_W'(32'(in_e))];
  assign hdr_init  = NODE_W'(NUM_ENTRIES + 32'(init_cnt_q));
  assign e_q_w     = 32'(e_q);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // whether the request touches the store at all
  always_comb begin
    case (in_kind)
      KIND_INS_HEAD, KIND_INS_TAIL: go = e_ok && q_ok;
      KIND_REM_HEAD, KIND_REM_TAIL: go = q_ok;
      KIND_UNLINK:                  go = e_ok && in_linked;
      default:                      go = 1'b0;
    endcase
  end

  // entry taken by a removal, from the header links just read
  assign x_sel = (kind_q == KIND_REM_HEAD) ? next_rd_q : prev_rd_q;
  assign x_ok  = 32'(x_sel) < NUM_ENTRIES;

  // queue state after a removal
  always_comb begin
    first_new = (p_q == h_q) ? n_q : f_q;
    last_new  = (n_q == h_q) ? p_q : l_q;
    if (first_new == h_q && last_new == h_q) begin
      rem_status = STS_NOWEMPTY;
    end else if (first_new == last_new) begin
      rem_status = STS_ONE;
    end else begin
      rem_status = STS_MORE;
    end
  end

  // queue state after an insert: the end not written by the insert itself
  always_comb begin
    if (kind_q == KIND_INS_HEAD) begin
      ins_other = (f_q == h_q) ? e_q : l_q;
    end else begin
      ins_other = (l_q == h_q) ? e_q : f_q;
    end
    ins_status = (ins_other == e_q) ? STS_ONE : STS_MORE;
  end

  // memory access per sequencer step
  always_comb begin
    nx_we   = 1'b0;
    pv_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = '0;
    pv_wa   = '0;
    pv_wd   = '0;
    iq_set  = 1'b0;
    iq_clr  = 1'b0;
    rd_addr = e_q;
    case (state_q)
      S_INIT: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wa = hdr_init;
        nx_wd = hdr_init;
        pv_wa = hdr_init;
        pv_wd = hdr_init;
      end
      S_IDLE: begin
        rd_addr = (in_kind == KIND_UNLINK) ? in_e_node : in_h;
      end
      S_RD1: begin
        rd_addr = x_sel;
        case (kind_q)
          KIND_INS_HEAD: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            nx_wa = e_q;
            nx_wd = next_rd_q;
            pv_wa = e_q;
            pv_wd = h_q;
          end
          KIND_INS_TAIL: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            nx_wa = e_q;
            nx_wd = h_q;
            pv_wa = e_q;
            pv_wd = prev_rd_q;
          end
          KIND_UNLINK: begin
            // splice neighbors together
            nx_we = 1'b1;
            pv_we = 1'b1;
            nx_wa = prev_rd_q;
            nx_wd = next_rd_q;
            pv_wa = next_rd_q;
            pv_wd = prev_rd_q;
          end
          default: begin
          end
        endcase
      end
      S_RD2: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wa = prev_rd_q;
        nx_wd = next_rd_q;
        pv_wa = next_rd_q;
        pv_wd = prev_rd_q;
      end
      S_DET2: begin
        // clear the detached entry
        nx_we  = 1'b1;
        pv_we  = 1'b1;
        nx_wa  = e_q;
        pv_wa  = e_q;
        iq_clr = 1'b1;
      end
      S_INS2: begin
        nx_we  = 1'b1;
        pv_we  = 1'b1;
        iq_set = 1'b1;
        if (kind_q == KIND_INS_HEAD) begin
          pv_wa = f_q;
          pv_wd = e_q;
          nx_wa = h_q;
          nx_wd = e_q;
        end else begin
          nx_wa = l_q;
          nx_wd = e_q;
          pv_wa = h_q;
          pv_wd = e_q;
        end
      end
      default: begin
      end
    endcase
  end

  // next link memory
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    next_rd_q <= next_mem[rd_addr];
  end

  // prev link memory
  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    prev_rd_q <= prev_mem[rd_addr];
  end

  // entry membership bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_queue_q <= '0;
    end else if (iq_set) begin
      in_queue_q[e_q[ENTRY_W-1:0]] <= 1'b1;
    end else if (iq_clr) begin
      in_queue_q[e_q[ENTRY_W-1:0]] <= 1'b0;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_INS_HEAD;
      out_status_q <= STS_WASEMPTY;
      out_evalid_q <= 1'b0;
      out_entry_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          init_cnt_q <= init_cnt_q + 1'b1;
          if (init_cnt_q == QW'(NUM_QUEUES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_q <= in_kind;
            h_q    <= in_h;
            e_q    <= in_e_node;
            if (go) begin
              state_q <= S_RD1;
            end else begin
              out_valid_q  <= 1'b1;
              out_status_q <= STS_WASEMPTY;
              out_evalid_q <= 1'b0;
              out_entry_q  <= '0;
            end
          end
        end
        S_RD1: begin
          f_q <= next_rd_q;
          l_q <= prev_rd_q;
          case (kind_q)
            KIND_INS_HEAD, KIND_INS_TAIL: state_q <= S_INS2;
            KIND_REM_HEAD, KIND_REM_TAIL: begin
              if (x_ok) begin
                e_q     <= x_sel;
                state_q <= S_RD2;
              end else begin
                out_valid_q  <= 1'b1;
                out_status_q <= STS_WASEMPTY;
                out_evalid_q <= 1'b0;
                out_entry_q  <= '0;
                state_q      <= S_IDLE;
              end
            end
            default: state_q <= S_DET2;
          endcase
        end
        S_RD2: begin
          p_q     <= prev_rd_q;
          n_q     <= next_rd_q;
          state_q <= S_DET2;
        end
        S_DET2: begin
          out_valid_q  <= 1'b1;
          out_status_q <= (kind_q == KIND_UNLINK) ? STS_MORE : rem_status;
          out_evalid_q <= 1'b1;
          out_entry_q  <= e_q_w[EIDX_W-1:0];
          state_q      <= S_IDLE;
        end
        S_INS2: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ins_status;
          out_evalid_q <= 1'b0;
          out_entry_q  <= '0;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_entry_q;
  assign m_axis_tuser  = {out_evalid_q, out_status_q};

  // no request taken while a result is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while result stalled");

  // removed entry field is zero unless an entry was removed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata == '0))
    else $error("removed entry set without entry valid");

  // a result that carries an entry never reports the was-empty status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] != STS_WASEMPTY))
    else $error("entry removed with was-empty status");

  // an insert leaves its entry marked linked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS2) |=> in_queue_q[e_q[ENTRY_W-1:0]])
    else $error("inserted entry not marked linked");

  // header clearing pass produces no results and takes no requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (!m_axis_tvalid && !s_axis_tready))
    else $error("traffic during header clearing pass");

endmodule

`default_nettype wire

// ===== dv/lnkdq_checker.sv =====
// Checker for the linked deque manager: tracks the queues and compares each result
`timescale 1ns / 1ps

module lnkdq_checker
  import lnkdq_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // tdata: queue_index [1:0], entry_index [9:2], zero [15:10]
  input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
  // tuser: kind [2:0]
  input  logic [KIND_W-1:0]           s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: removed_entry [7:0]
  input  logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: status [1:0], entry_valid [2]
  input  logic [OUT_TUSER_W-1:0]      m_axis_tuser,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output logic [NUM_ENTRIES_DEF-1:0]  linked_o,
  output logic [NUM_QUEUES_DEF-1:0]   queue_empty_o
);

  localparam int unsigned NODE_COUNT = NUM_ENTRIES_DEF + NUM_QUEUES_DEF;
  localparam int unsigned NODE_W     = 9;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    status_e           status;
    logic              has_entry;
    logic [EIDX_W-1:0] entry;
  } deque_result_t;

  // shadow of the link store: entries first, then one header per queue
  logic [NODE_W-1:0]          node_next [NODE_COUNT];
  logic [NODE_W-1:0]          node_prev [NODE_COUNT];
  logic [NUM_ENTRIES_DEF-1:0] entry_linked;

  deque_result_t expected_results [$];
  deque_result_t oldest;
  deque_result_t observed;

  assign linked_o = entry_linked;

  function automatic logic [NODE_W-1:0] header_of(input logic [QIDX_W-1:0] q);
    return NODE_W'(NUM_ENTRIES_DEF) + NODE_W'(q);
  endfunction

  function automatic status_e occupancy(input logic [NODE_W-1:0] hdr);
    if (node_next[hdr] == hdr && node_prev[hdr] == hdr) return STS_NOWEMPTY;
    if (node_next[hdr] == node_prev[hdr]) return STS_ONE;
    return STS_MORE;
  endfunction

  // take a node out of its ring and mark it free
  function automatic void unlink_node(input logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] p;
    logic [NODE_W-1:0] n;
    p = node_prev[x];
    n = node_next[x];
    node_next[p] = n;
    node_prev[n] = p;
    node_next[x] = '0;
    node_prev[x] = '0;
    entry_linked[x[EIDX_W-1:0]] = 1'b0;
  endfunction

  function automatic void clear_queues();
    for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
      node_next[i] = '0;
      node_prev[i] = '0;
    end
    for (int q = 0; q < NUM_QUEUES_DEF; q++) begin
      node_next[NUM_ENTRIES_DEF + q] = header_of(QIDX_W'(q));
      node_prev[NUM_ENTRIES_DEF + q] = header_of(QIDX_W'(q));
    end
    entry_linked = '0;
  endfunction

  // apply one request to the shadow store and return the result it gives
  function automatic deque_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [QIDX_W-1:0] q,
                                                  input logic [EIDX_W-1:0] e);
    deque_result_t     r;
    logic [NODE_W-1:0] hdr;
    logic [NODE_W-1:0] ent;
    logic [NODE_W-1:0] node;
    r.status    = STS_WASEMPTY;
    r.has_entry = 1'b0;
    r.entry     = '0;
    hdr = header_of(q);
    ent = NODE_W'(e);
    case (kind)
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (kind == KIND_INS_HEAD) begin
          node = node_next[hdr];
          node_next[ent] = node;
          node_prev[ent] = hdr;
          node_prev[node] = ent;
          node_next[hdr] = ent;
        end else begin
          node = node_prev[hdr];
          node_prev[ent] = node;
          node_next[ent] = hdr;
          node_next[node] = ent;
          node_prev[hdr] = ent;
        end
        entry_linked[e] = 1'b1;
        r.status = (node_next[hdr] == node_prev[hdr]) ? STS_ONE : STS_MORE;
      end
      KIND_REM_HEAD, KIND_REM_TAIL: begin
        node = (kind == KIND_REM_HEAD) ? node_next[hdr] : node_prev[hdr];
        // a header reached through stale links counts as nothing done
        if (node < NODE_W'(NUM_ENTRIES_DEF)) begin
          unlink_node(node);
          r.status    = occupancy(hdr);
          r.has_entry = 1'b1;
          r.entry     = node[EIDX_W-1:0];
        end
      end
      KIND_UNLINK: begin
        if (entry_linked[e]) begin
          unlink_node(ent);
          r.status    = STS_MORE;
          r.has_entry = 1'b1;
          r.entry     = e;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS)
      $display("[%0t] %s: expected status %0d valid %0d entry %0d, got status %0d valid %0d entry %0d",
               $realtime, what, oldest.status, oldest.has_entry, oldest.entry,
               observed.status, observed.has_entry, observed.entry);
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_queues();
      expected_results.delete();
      pending_o     = 0;
      queue_empty_o = '1;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_request(s_axis_tuser,
                                                 s_axis_tdata[QIDX_W-1:0],
                                                 s_axis_tdata[QIDX_W +: EIDX_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        observed.status    = status_e'(m_axis_tuser[STATUS_W-1:0]);
        observed.has_entry = m_axis_tuser[STATUS_W];
        observed.entry     = m_axis_tdata[EIDX_W-1:0];
        if (expected_results.size() == 0) begin
          oldest = '0;
          note_failure("result with no request pending");
        end else begin
          oldest = expected_results.pop_front();
          checked_o++;
          if (observed.status != oldest.status || observed.has_entry != oldest.has_entry ||
              observed.entry != oldest.entry)
            note_failure("result mismatch");
        end
      end
      pending_o = expected_results.size();
      for (int q = 0; q < NUM_QUEUES_DEF; q++)
        queue_empty_o[q] = (occupancy(header_of(QIDX_W'(q))) == STS_NOWEMPTY);
    end
  end

endmodule

// ===== dv/linked_deque_manager_tb.sv =====
// Testbench top for the linked deque manager: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module linked_deque_manager_tb;
  import lnkdq_pkg::*;

  // kinds with no operation behind them
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 820;
  localparam int unsigned DRAIN_POINT  = 500;
  localparam int unsigned HOLD_START   = 600;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned END_WAIT     = 5000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned FULL_LINKED  = 180;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  int                         fail_count;
  int                         pending;
  int                         checked;
  logic [NUM_ENTRIES_DEF-1:0] linked;
  logic [NUM_QUEUES_DEF-1:0]  queue_empty;

  int unsigned burst_left = 0;
  int unsigned n_insert = 0;
  int unsigned n_remove = 0;
  int unsigned n_unlink = 0;
  int unsigned n_spare = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  linked_deque_manager uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lnkdq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .linked_o      (linked),
    .queue_empty_o (queue_empty)
  );

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // result side: stall mode changes now and then, one long hold early in the run
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
      m_axis_tready <= 1'b0;
    else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one request in bursts with random gaps, return at the negedge after acceptance
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [QIDX_W-1:0] q,
                       input logic [EIDX_W-1:0] e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {{(IN_TDATA_W - QIDX_W - EIDX_W){1'b0}}, e, q};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    case (kind)
      KIND_INS_HEAD, KIND_INS_TAIL: n_insert++;
      KIND_REM_HEAD, KIND_REM_TAIL: n_remove++;
      KIND_UNLINK: n_unlink++;
      default: n_spare++;
    endcase
  endtask

  // random entry that is (or is not) in a queue; bit 8 set when none exists
  function automatic logic [EIDX_W:0] find_entry(input logic want_linked);
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, NUM_ENTRIES_DEF - 1);
    for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
      idx = (start + i) % NUM_ENTRIES_DEF;
      if (linked[idx] == want_linked) return {1'b0, EIDX_W'(idx)};
    end
    return {1'b1, EIDX_W'(start)};
  endfunction

  // mostly well-formed traffic: free entries inserted, linked ones unlinked
  task automatic random_request();
    int unsigned       pick;
    int unsigned       insert_share;
    logic [EIDX_W:0]   found;
    logic [KIND_W-1:0] kind;
    logic [QIDX_W-1:0] q;
    logic [EIDX_W-1:0] e;
    pick = $urandom_range(0, 99);
    insert_share = ($countones(linked) > FULL_LINKED) ? 25 : 50;
    q = $urandom_range(0, NUM_QUEUES_DEF - 1);
    e = $urandom_range(0, NUM_ENTRIES_DEF - 1);
    kind = $urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL;
    if (pick < 5) begin
      kind = $urandom_range(KIND_SPARE_LO, KIND_SPARE_HI);
    end else if (pick < insert_share) begin
      found = find_entry(1'b0);
      if (!found[EIDX_W]) begin
        kind = $urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL;
        e = found[EIDX_W-1:0];
      end
    end else if (pick >= 80) begin
      kind = KIND_UNLINK;
      found = find_entry(1'b1);
      if ($urandom_range(0, 4) != 0 && !found[EIDX_W]) e = found[EIDX_W-1:0];
    end
    issue(kind, q, e);
  endtask

  initial begin
    logic [EIDX_W-1:0] ent_a;
    logic [EIDX_W-1:0] ent_b;
    int unsigned       waited;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, empty removals, spare kinds, unlink cases
    issue(KIND_INS_HEAD, 2'd0, 8'd0);
    issue(KIND_INS_TAIL, 2'd0, 8'd255);
    issue(KIND_INS_HEAD, 2'd3, 8'd128);
    issue(KIND_INS_TAIL, 2'd3, 8'd127);
    issue(KIND_INS_HEAD, 2'd1, 8'd1);
    issue(KIND_REM_HEAD, 2'd2, 8'd255);
    issue(KIND_REM_TAIL, 2'd2, 8'd0);
    issue(KIND_UNLINK, 2'd3, 8'd200);
    issue(KIND_SPARE_LO, 2'd1, 8'd3);
    issue(KIND_SPARE_MID, 2'd2, 8'd170);
    issue(KIND_SPARE_HI, 2'd3, 8'd85);
    issue(KIND_REM_TAIL, 2'd0, 8'd17);
    issue(KIND_REM_HEAD, 2'd0, 8'd0);
    issue(KIND_UNLINK, 2'd0, 8'd127);
    issue(KIND_UNLINK, 2'd2, 8'd1);
    issue(KIND_REM_TAIL, 2'd3, 8'd0);
    issue(KIND_INS_TAIL, 2'd2, 8'd2);
    issue(KIND_INS_HEAD, 2'd2, 8'd3);
    issue(KIND_INS_TAIL, 2'd2, 8'd4);
    issue(KIND_UNLINK, 2'd1, 8'd2);
    issue(KIND_REM_HEAD, 2'd2, 8'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // once, let everything drain before going on
      if (i == DRAIN_POINT) begin
        while (pending != 0) @(negedge clk_i);
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      random_request();
    end

    // empty queues 0 and 1, then re-insert a linked entry so that a removal reaches a header
    while (!queue_empty[0]) issue(KIND_REM_HEAD, 2'd0, 8'($urandom));
    while (!queue_empty[1]) issue(KIND_REM_TAIL, 2'd1, 8'($urandom));
    ent_a = find_entry(1'b0);
    issue(KIND_INS_TAIL, 2'd1, ent_a);
    ent_b = find_entry(1'b0);
    issue(KIND_INS_TAIL, 2'd1, ent_b);
    issue(KIND_INS_HEAD, 2'd0, ent_a);
    issue(KIND_UNLINK, 2'd2, ent_b);
    issue(KIND_UNLINK, 2'd3, ent_a);
    issue(KIND_REM_HEAD, 2'd0, 8'd0);
    issue(KIND_REM_TAIL, 2'd1, 8'd0);

    waited = 0;
    while (pending != 0 && waited < END_WAIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending != 0) begin
      $display("FAIL");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      $display("covered %0d requests: %0d inserts, %0d removals, %0d unlinks, %0d spare kinds",
               n_insert + n_remove + n_unlink + n_spare, n_insert, n_remove, n_unlink,
               n_spare);
      $display("%0d results compared, %0d mismatches", checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
